// ===== rtl/core/brls_pkg.sv =====
// Shared types and constants for the Bresenham line stepper.
package brls_pkg;

    localparam int COORD_W            = 16;
    localparam int DELTA_W            = COORD_W + 1;
    localparam int ERR_W              = COORD_W + 2;
    localparam int MAX_POINTS_DEFAULT = 2048;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DELTA_W-1:0] sdelta_t;
    typedef logic        [DELTA_W-1:0] udelta_t;
    typedef logic signed [ERR_W-1:0]   err_t;

    // Request codes carried in req_type
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_t;

endpackage

// ===== rtl/core/bresenham_line_stepper.sv =====
// Bresenham line stepper: one point per transaction, start or step requests.
//
// A start request (req_type 0) loads two signed 16-bit endpoints and returns the
// first point; each step request (req_type 1) returns the next point of the line.
// The major axis is the one with the larger absolute delta (ties pick y) and the
// major coordinate always increases. The final point carries last_point; if the
// point count reaches MAX_POINTS-1 the line stops there with truncated and
// last_point both set. Step requests while no line is active are taken and
// give no result. Every request is handled by a single add, compare
// and increment stage between the request port and the result register, so a
// new request can be accepted every cycle; the result register is the only
// buffering, and requests stall only while a result is held by out_ready low.
module bresenham_line_stepper #(
    parameter int MAX_POINTS = brls_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  brls_pkg::coord_t      start_x,
    input  brls_pkg::coord_t      start_y,
    input  brls_pkg::coord_t      end_x,
    input  brls_pkg::coord_t      end_y,

    output logic                  out_valid,
    input  logic                  out_ready,
    output brls_pkg::coord_t      point_x,
    output brls_pkg::coord_t      point_y,
    output logic                  last_point,
    output logic                  truncated
);

    localparam int                CNT_W     = $clog2(MAX_POINTS);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(MAX_POINTS - 1);

    // Line state
    brls_pkg::coord_t   cur_x_reg, cur_x_next;
    brls_pkg::coord_t   cur_y_reg, cur_y_next;
    brls_pkg::coord_t   major_end_reg, major_end_next;
    brls_pkg::err_t     error_term_reg, error_term_next;
    brls_pkg::udelta_t  major_delta_reg, major_delta_next;
    brls_pkg::udelta_t  minor_delta_reg, minor_delta_next;
    logic               minor_step_down_reg, minor_step_down_next;
    logic               x_is_major_reg, x_is_major_next;
    logic               line_active_reg, line_active_next;
    logic [CNT_W-1:0]   point_count_reg, point_count_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    brls_pkg::coord_t   point_x_reg, point_x_next;
    brls_pkg::coord_t   point_y_reg, point_y_next;
    logic               last_point_reg, last_point_next;
    logic               truncated_reg, truncated_next;

    // Start path terms
    brls_pkg::sdelta_t  dx, dy;
    brls_pkg::udelta_t  abs_dx, abs_dy;
    logic               start_x_major;
    logic               start_swap;
    brls_pkg::coord_t   first_x, first_y, last_x, last_y;

    // Step path terms
    brls_pkg::err_t     err_sum;
    brls_pkg::coord_t   minor_inc;

    // Emit terms
    logic               in_accept;
    logic               emit;
    brls_pkg::coord_t   major_pos;
    logic               at_end;
    logic               trunc_hit;

    assign in_accept = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;

    // Endpoint ordering for a start request
    always_comb
    begin
        dx            = brls_pkg::sdelta_t'(end_x) - brls_pkg::sdelta_t'(start_x);
        dy            = brls_pkg::sdelta_t'(end_y) - brls_pkg::sdelta_t'(start_y);
        abs_dx        = dx[brls_pkg::DELTA_W-1] ? brls_pkg::udelta_t'(-dx)
                                                : brls_pkg::udelta_t'(dx);
        abs_dy        = dy[brls_pkg::DELTA_W-1] ? brls_pkg::udelta_t'(-dy)
                                                : brls_pkg::udelta_t'(dy);
        start_x_major = abs_dx > abs_dy;
        start_swap    = start_x_major ? dx[brls_pkg::DELTA_W-1] : dy[brls_pkg::DELTA_W-1];
        first_x       = start_swap ? end_x   : start_x;
        first_y       = start_swap ? end_y   : start_y;
        last_x        = start_swap ? start_x : end_x;
        last_y        = start_swap ? start_y : end_y;
    end

    // Next line state and result
    always_comb
    begin
        cur_x_next           = cur_x_reg;
        cur_y_next           = cur_y_reg;
        major_end_next       = major_end_reg;
        error_term_next      = error_term_reg;
        major_delta_next     = major_delta_reg;
        minor_delta_next     = minor_delta_reg;
        minor_step_down_next = minor_step_down_reg;
        x_is_major_next      = x_is_major_reg;
        line_active_next     = line_active_reg;
        point_count_next     = point_count_reg;
        emit                 = 1'b0;

        err_sum   = error_term_reg + brls_pkg::err_t'(minor_delta_reg);
        minor_inc = minor_step_down_reg ? -brls_pkg::coord_t'(1) : brls_pkg::coord_t'(1);

        if (in_accept)
        begin
            case (brls_pkg::req_t'(req_type))
                brls_pkg::REQ_START:
                begin
                    emit                 = 1'b1;
                    x_is_major_next      = start_x_major;
                    cur_x_next           = first_x;
                    cur_y_next           = first_y;
                    point_count_next     = '0;
                    line_active_next     = 1'b1;
                    if (start_x_major)
                    begin
                        major_end_next       = last_x;
                        major_delta_next     = abs_dx;
                        minor_delta_next     = abs_dy;
                        minor_step_down_next = !(last_y > first_y);
                    end
                    else
                    begin
                        major_end_next       = last_y;
                        major_delta_next     = abs_dy;
                        minor_delta_next     = abs_dx;
                        minor_step_down_next = !(last_x > first_x);
                    end
                    error_term_next = -brls_pkg::err_t'(major_delta_next >> 1);
                end
                brls_pkg::REQ_STEP:
                begin
                    if (line_active_reg)
                    begin
                        emit            = 1'b1;
                        error_term_next = err_sum;
                        if (err_sum > 0)
                        begin
                            error_term_next = err_sum - brls_pkg::err_t'(major_delta_reg);
                            if (x_is_major_reg)
                                cur_y_next = cur_y_reg + minor_inc;
                            else
                                cur_x_next = cur_x_reg + minor_inc;
                        end
                        if (x_is_major_reg)
                            cur_x_next = cur_x_next + brls_pkg::coord_t'(1);
                        else
                            cur_y_next = cur_y_next + brls_pkg::coord_t'(1);
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        // Emit the new current point
        major_pos = x_is_major_next ? cur_x_next : cur_y_next;
        at_end    = major_pos >= major_end_next;
        trunc_hit = 1'b0;
        if (emit)
        begin
            point_count_next = point_count_next + CNT_W'(1);
            trunc_hit        = point_count_next >= CNT_LIMIT;
            if (trunc_hit || at_end)
                line_active_next = 1'b0;
        end

        // Result register update
        point_x_next    = point_x_reg;
        point_y_next    = point_y_reg;
        last_point_next = last_point_reg;
        truncated_next  = truncated_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            point_x_next    = cur_x_next;
            point_y_next    = cur_y_next;
            last_point_next = trunc_hit || at_end;
            truncated_next  = trunc_hit;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg           <= '0;
            cur_y_reg           <= '0;
            major_end_reg       <= '0;
            error_term_reg      <= '0;
            major_delta_reg     <= '0;
            minor_delta_reg     <= '0;
            minor_step_down_reg <= 1'b0;
            x_is_major_reg      <= 1'b0;
            line_active_reg     <= 1'b0;
            point_count_reg     <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cur_x_reg           <= cur_x_next;
            cur_y_reg           <= cur_y_next;
            major_end_reg       <= major_end_next;
            error_term_reg      <= error_term_next;
            major_delta_reg     <= major_delta_next;
            minor_delta_reg     <= minor_delta_next;
            minor_step_down_reg <= minor_step_down_next;
            x_is_major_reg      <= x_is_major_next;
            line_active_reg     <= line_active_next;
            point_count_reg     <= point_count_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        point_x_reg    <= point_x_next;
        point_y_reg    <= point_y_next;
        last_point_reg <= last_point_next;
        truncated_reg  <= truncated_next;
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign last_point = last_point_reg;
    assign truncated  = truncated_reg;

endmodule

// ===== tb/tb_bresenham_line_stepper.sv =====
// Self-checking testbench for the Bresenham line stepper.
module tb_bresenham_line_stepper;

    localparam int MAX_PTS        = brls_pkg::MAX_POINTS_DEFAULT;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_POINTS  = 400;
    localparam int CHUNKS         = 10;

    typedef struct packed {
        brls_pkg::coord_t x;
        brls_pkg::coord_t y;
        logic             last;
        logic             trunc;
    } point_t;

    typedef enum int {
        RECV_FREE,
        RECV_PATTERN,
        RECV_SLOW
    } recv_mode_t;

    // Line predictor plus queue of expected points
    class line_scoreboard;
        int     limit_points;
        int     pos_x;
        int     pos_y;
        int     major_stop;
        int     err_acc;
        int     dmaj;
        int     dmin;
        bit     minor_down;
        bit     along_x;
        bit     active;
        int     emitted;
        point_t want_q[$];
        int     predicted;
        int     errors;

        function new(int max_points);
            limit_points = max_points;
            pos_x        = 0;
            pos_y        = 0;
            major_stop   = 0;
            err_acc      = 0;
            dmaj         = 0;
            dmin         = 0;
            minor_down   = 1'b0;
            along_x      = 1'b0;
            active       = 1'b0;
            emitted      = 0;
            predicted    = 0;
            errors       = 0;
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        // Queue the current point, end the line at the endpoint or count limit
        function void push_point();
            point_t p;
            bit     hit_limit;
            bit     at_end;
            emitted++;
            hit_limit = (emitted >= limit_points - 1);
            at_end    = ((along_x ? pos_x : pos_y) >= major_stop);
            p.x       = brls_pkg::coord_t'(pos_x);
            p.y       = brls_pkg::coord_t'(pos_y);
            p.last    = hit_limit || at_end;
            p.trunc   = hit_limit;
            if (hit_limit || at_end)
                active = 1'b0;
            want_q.push_back(p);
            predicted++;
        endfunction

        // Accepted request transaction
        function void note_request(brls_pkg::req_t kind,
                                   brls_pkg::coord_t sx, brls_pkg::coord_t sy,
                                   brls_pkg::coord_t ex, brls_pkg::coord_t ey);
            int x1;
            int y1;
            int x2;
            int y2;
            int dx;
            int dy;
            int tmp;
            if (kind == brls_pkg::REQ_START)
            begin
                x1 = sx;
                y1 = sy;
                x2 = ex;
                y2 = ey;
                dx = x2 - x1;
                dy = y2 - y1;
                along_x = magnitude(dx) > magnitude(dy);
                // order endpoints so the major coordinate increases
                if ((along_x && dx < 0) || (!along_x && dy < 0))
                begin
                    tmp = x1; x1 = x2; x2 = tmp;
                    tmp = y1; y1 = y2; y2 = tmp;
                end
                if (along_x)
                begin
                    major_stop = x2;
                    dmaj       = magnitude(dx);
                    dmin       = magnitude(dy);
                    minor_down = !(y2 > y1);
                end
                else
                begin
                    major_stop = y2;
                    dmaj       = magnitude(dy);
                    dmin       = magnitude(dx);
                    minor_down = !(x2 > x1);
                end
                err_acc = -(dmaj / 2);
                pos_x   = x1;
                pos_y   = y1;
                emitted = 0;
                active  = 1'b1;
                push_point();
            end
            else if (active)
            begin
                err_acc += dmin;
                if (err_acc > 0)
                begin
                    if (along_x)
                        pos_y += minor_down ? -1 : 1;
                    else
                        pos_x += minor_down ? -1 : 1;
                    err_acc -= dmaj;
                end
                if (along_x)
                    pos_x++;
                else
                    pos_y++;
                push_point();
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        // Accepted result transaction
        function void check_point(point_t got);
            point_t want;
            if (want_q.size() == 0)
            begin
                report($sformatf("unexpected point x=%0d y=%0d last=%0b trunc=%0b",
                                 got.x, got.y, got.last, got.trunc));
                return;
            end
            want = want_q.pop_front();
            if (got.x !== want.x || got.y !== want.y ||
                got.last !== want.last || got.trunc !== want.trunc)
                report($sformatf({"point mismatch: expected x=%0d y=%0d last=%0b trunc=%0b,",
                                  " got x=%0d y=%0d last=%0b trunc=%0b"},
                                 want.x, want.y, want.last, want.trunc,
                                 got.x, got.y, got.last, got.trunc));
        endfunction
    endclass

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_ready;
    logic             req_type   = brls_pkg::REQ_START;
    brls_pkg::coord_t start_x    = '0;
    brls_pkg::coord_t start_y    = '0;
    brls_pkg::coord_t end_x      = '0;
    brls_pkg::coord_t end_y      = '0;
    logic             out_valid;
    logic             out_ready  = 1'b0;
    brls_pkg::coord_t point_x;
    brls_pkg::coord_t point_y;
    logic             last_point;
    logic             truncated;

    line_scoreboard sb = new(MAX_PTS);

    recv_mode_t recv_mode    = RECV_FREE;
    bit         hold_request = 1'b0;
    bit         bursty       = 1'b0;
    int         burst_left   = 0;
    int         stall_cycles = 0;

    bresenham_line_stepper #(
        .MAX_POINTS (MAX_PTS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .truncated  (truncated)
    );

    always #5 clk = ~clk;

    // Monitor: results are checked before the same-edge request is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_point('{x: point_x, y: point_y, last: last_point, trunc: truncated});
            if (in_valid && in_ready)
                sb.note_request(brls_pkg::req_t'(req_type), start_x, start_y, end_x, end_y);
        end
    end

    // Receiver: long hold-off on request, otherwise the selected stall pattern
    initial
    begin
        bit [7:0] stall_pattern;
        bit [2:0] pat_idx;
        stall_pattern = 8'hff;
        pat_idx       = 3'd0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                case (recv_mode)
                    RECV_FREE:
                        out_ready <= 1'b1;
                    RECV_PATTERN:
                    begin
                        if (pat_idx == 3'd0)
                            stall_pattern = 8'($urandom);
                        out_ready <= stall_pattern[pat_idx];
                        pat_idx++;
                    end
                    default:
                        out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: cycles without any transaction on either side
    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one request and hold it until accepted; bursty mode adds gaps
    task automatic send_request(brls_pkg::req_t kind,
                                brls_pkg::coord_t sx, brls_pkg::coord_t sy,
                                brls_pkg::coord_t ex, brls_pkg::coord_t ey);
        in_valid <= 1'b1;
        req_type <= kind;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        do
            @(posedge clk);
        while (!in_ready);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    // Stop offering until every expected point has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Start a line, then issue step requests with junk coordinates
    task automatic run_line(brls_pkg::coord_t sx, brls_pkg::coord_t sy,
                            brls_pkg::coord_t ex, brls_pkg::coord_t ey, int steps);
        send_request(brls_pkg::REQ_START, sx, sy, ex, ey);
        repeat (steps)
            send_request(brls_pkg::REQ_STEP,
                         brls_pkg::coord_t'($urandom), brls_pkg::coord_t'($urandom),
                         brls_pkg::coord_t'($urandom), brls_pkg::coord_t'($urandom));
    endtask

    function automatic brls_pkg::coord_t offset_coord(brls_pkg::coord_t base, int span);
        int off;
        int t;
        off = int'($urandom_range(0, 2 * span)) - span;
        t   = base + off;
        if (t > 32767 || t < -32768)
            t = base - off;
        return brls_pkg::coord_t'(t);
    endfunction

    // Mostly short complete lines; some abandoned, overrun or full-range
    task automatic random_line();
        int               kind;
        int               span;
        int               adx;
        int               ady;
        int               major;
        int               steps;
        brls_pkg::coord_t sx;
        brls_pkg::coord_t sy;
        brls_pkg::coord_t ex;
        brls_pkg::coord_t ey;
        kind = $urandom_range(0, 19);
        sx   = brls_pkg::coord_t'($urandom);
        sy   = brls_pkg::coord_t'($urandom);
        if (kind == 0)
        begin
            ex = brls_pkg::coord_t'($urandom);
            ey = brls_pkg::coord_t'($urandom);
        end
        else
        begin
            span = (kind < 15) ? $urandom_range(0, 12) : $urandom_range(13, 90);
            ex   = offset_coord(sx, span);
            ey   = offset_coord(sy, span);
        end
        adx   = int'(ex) - int'(sx);
        ady   = int'(ey) - int'(sy);
        adx   = (adx < 0) ? -adx : adx;
        ady   = (ady < 0) ? -ady : ady;
        major = (adx > ady) ? adx : ady;
        case ($urandom_range(0, 9))
            0:       steps = $urandom_range(0, major);
            1:       steps = major + $urandom_range(1, 3);
            default: steps = major;
        endcase
        if (kind == 0 && steps > 8)
            steps = $urandom_range(0, 8);
        run_line(sx, sy, ex, ey, steps);
    endtask

    // Main sequence
    initial
    begin
        int goal;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle step, single point, extremes, octants, ties
        recv_mode = RECV_PATTERN;
        send_request(brls_pkg::REQ_STEP, 16'sh7fff, -16'sh8000, 16'sh5555, -16'sh5556);
        run_line(16'sd5, -16'sd7, 16'sd5, -16'sd7, 1);
        run_line(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 2);
        run_line(16'sh7fff, 16'sd0, -16'sh8000, 16'sd1, 2);
        run_line(16'sd0, 16'sh7fff, 16'sd0, -16'sh8000, 1);
        run_line(16'sd0, 16'sd0, 16'sd3, 16'sd1, 3);
        run_line(16'sd0, 16'sd0, -16'sd3, 16'sd1, 3);
        run_line(16'sd0, 16'sd0, 16'sd1, -16'sd3, 3);
        run_line(16'sd2, 16'sd2, 16'sd0, 16'sd0, 2);
        wait_drain();

        // count limit reached on the endpoint, then one step after the line ends
        bursty    = 1'b1;
        recv_mode = RECV_SLOW;
        run_line(-16'sd1000, 16'sd7, 16'sd1046, 16'sd300, MAX_PTS - 1);
        bursty    = 1'b0;
        recv_mode = RECV_FREE;
        wait_drain();

        // random lines in chunks with varying flow control
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            if (chunk == 0)
            begin
                recv_mode = RECV_FREE;
                bursty    = 1'b0;
            end
            else
            begin
                recv_mode = recv_mode_t'($urandom_range(0, 2));
                bursty    = 1'($urandom_range(0, 1));
            end
            if (chunk == 3)
                hold_request = 1'b1;
            if (chunk == 6)
                wait_drain();
            goal = sb.predicted + RANDOM_POINTS / CHUNKS;
            while (sb.predicted < goal)
                random_line();
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
